@@ hw/rtl/one_wire_temperature_master_macros.svh @@
// ----------------------------------------------------------------------------
// One-wire temperature master assertion macros
// Concurrent assertion helpers clocked by clk_i and disabled during rst_ni.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_TEMPERATURE_MASTER_MACROS_SVH
`define ONE_WIRE_TEMPERATURE_MASTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define OWTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication outside reset.
`define OWTM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define OWTM_ASSERT(lbl, prop, msg)
`define OWTM_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

@@ hw/rtl/owtm_pkg.sv @@
// ----------------------------------------------------------------------------
// One-wire temperature master package
// Types, command codes and conversion helpers used by the master module.
// ----------------------------------------------------------------------------
package owtm_pkg;

  // Item kinds on the input channel.
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_RESET  = 3'd1;
  localparam logic [2:0] KIND_WRITE  = 3'd2;
  localparam logic [2:0] KIND_READ   = 3'd3;
  localparam logic [2:0] KIND_TEMP   = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_RESET_LOW    = 3'd0;
  localparam logic [2:0] CFG_RESET_WAIT   = 3'd1;
  localparam logic [2:0] CFG_RESET_TAIL   = 3'd2;
  localparam logic [2:0] CFG_SLOT_LOW     = 3'd3;
  localparam logic [2:0] CFG_SLOT_SAMPLE  = 3'd4;
  localparam logic [2:0] CFG_SLOT_HOLD    = 3'd5;
  localparam logic [2:0] CFG_PRES_TIMEOUT = 3'd6;

  // One-wire ROM and function commands.
  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_READ_PAD = 8'hBE;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;

  // Steps of the command sequencer. Steps 0 to 8 form the temperature read.
  localparam logic [3:0] STEP_FIRST      = 4'd0;
  localparam logic [3:0] STEP_SKIP_A     = 4'd1;
  localparam logic [3:0] STEP_READ_PAD   = 4'd2;
  localparam logic [3:0] STEP_LOW_BYTE   = 4'd3;
  localparam logic [3:0] STEP_HIGH_BYTE  = 4'd4;
  localparam logic [3:0] STEP_RESET_END  = 4'd5;
  localparam logic [3:0] STEP_RESET_CONV = 4'd6;
  localparam logic [3:0] STEP_SKIP_B     = 4'd7;
  localparam logic [3:0] STEP_LAST_TEMP  = 4'd8;
  localparam logic [3:0] STEP_RESET      = 4'd9;
  localparam logic [3:0] STEP_WRITE      = 4'd10;
  localparam logic [3:0] STEP_READ       = 4'd11;

  // Bus sequencer phases.
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_R_LOW  = 4'd1,
    PH_R_WAIT = 4'd2,
    PH_R_PRES = 4'd3,
    PH_R_TAIL = 4'd4,
    PH_W_LOW  = 4'd5,
    PH_W_HOLD = 4'd6,
    PH_W_REC  = 4'd7,
    PH_D_LOW  = 4'd8,
    PH_D_WAIT = 4'd9,
    PH_D_HOLD = 4'd10
  } phase_e;

  // One result item.
  typedef struct packed {
    logic        drive_low;
    logic        busy_res;
    logic        cmd_done;
    logic [7:0]  read_value;
    logic [15:0] temperature;
    logic        presence;
  } res_t;

  // Bus drive for a phase; during a write hold it follows the current bit.
  function automatic logic drive_of(phase_e ph, logic bit0);
    logic drv;
    case (ph)
      PH_R_LOW, PH_W_LOW, PH_D_LOW: drv = 1'b1;
      PH_W_HOLD:                    drv = ~bit0;
      default:                      drv = 1'b0;
    endcase
    return drv;
  endfunction

  // Command byte sent by a write step of the temperature sequence.
  function automatic logic [7:0] step_code(logic [3:0] step);
    logic [7:0] code;
    case (step)
      STEP_SKIP_A:    code = CMD_SKIP_ROM;
      STEP_READ_PAD:  code = CMD_READ_PAD;
      STEP_SKIP_B:    code = CMD_SKIP_ROM;
      STEP_LAST_TEMP: code = CMD_CONVERT;
      default:        code = 8'h00;
    endcase
    return code;
  endfunction

  // Sixteenths of a degree rounded to the nearest tenth.
  function automatic logic [7:0] tenths_of(logic [3:0] frac);
    logic [7:0] t;
    case (frac)
      4'd0:    t = 8'd0;
      4'd1:    t = 8'd1;
      4'd2:    t = 8'd1;
      4'd3:    t = 8'd2;
      4'd4:    t = 8'd3;
      4'd5:    t = 8'd3;
      4'd6:    t = 8'd4;
      4'd7:    t = 8'd4;
      4'd8:    t = 8'd5;
      4'd9:    t = 8'd6;
      4'd10:   t = 8'd6;
      4'd11:   t = 8'd7;
      4'd12:   t = 8'd8;
      4'd13:   t = 8'd8;
      4'd14:   t = 8'd9;
      default: t = 8'd9;
    endcase
    return t;
  endfunction

  // Raw scratchpad bytes to sign, integer degrees and tenths.
  function automatic logic [15:0] convert_temp(logic [7:0] lo, logic [7:0] hi);
    logic [7:0] h;
    logic [7:0] l;
    h = hi;
    l = lo;
    if (hi[7]) begin
      h = ~hi | 8'h08;
      l = 8'd0 - lo;
      if (l == 8'h00) begin
        h = h + 8'd1;
      end
    end
    return {h[3:0], l[7:4], tenths_of(l[3:0])};
  endfunction

endpackage

@@ hw/rtl/owtm_if.sv @@
// ----------------------------------------------------------------------------
// One-wire temperature master channel interfaces
// Valid/ready channels for commands and ticks, results and register writes.
// ----------------------------------------------------------------------------
interface owtm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic       line_level;
  logic [7:0] data_byte;

  modport source (output valid, kind, line_level, data_byte, input ready);
  modport sink   (input valid, kind, line_level, data_byte, output ready);
endinterface

interface owtm_out_if;
  logic        valid;
  logic        ready;
  logic        drive_low;
  logic        busy_res;
  logic        cmd_done;
  logic [7:0]  read_value;
  logic [15:0] temperature;
  logic        presence;

  modport source (output valid, drive_low, busy_res, cmd_done, read_value, temperature,
                  presence, input ready);
  modport sink   (input valid, drive_low, busy_res, cmd_done, read_value, temperature,
                  presence, output ready);
endinterface

interface owtm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/one_wire_temperature_master.sv @@
// ----------------------------------------------------------------------------
// One-wire temperature master
// Open-drain one-wire bus sequencer with reset/presence, byte write, byte
// read and a complete temperature read sequence.
// ----------------------------------------------------------------------------
// Usage: every item on in_i is a tick (one bus time unit with the sampled
// line level) or a command (reset, write byte, read byte, read temperature).
// Commands that arrive while a command is running are dropped. Each item
// yields exactly one result item on out_o carrying the bus drive, busy and
// done flags, the received byte, the last temperature and the presence flag.
// An accepted item is held in the input register, then passes through the
// sequencer logic into the result register. One item is taken per cycle
// while out_o does not stall; the sequencer state update is a single
// pass of timer compare and phase selection per item.
// Register writes on cfg_i are always taken and should be made while idle.
// Reset returns the sequencer to idle, clears the stored temperature and the
// presence flag, and loads the default tick counts. When out_o stalls, the
// held result stays put and the input register fills, after which in_i
// deasserts ready until the receiver takes the result.
// ----------------------------------------------------------------------------
`include "one_wire_temperature_master_macros.svh"

module one_wire_temperature_master (
  input  logic clk_i,
  input  logic rst_ni,
  owtm_in_if.sink    in_i,
  owtm_out_if.source out_o,
  owtm_cfg_if.sink   cfg_i
);

  // Configuration registers.
  logic [15:0] reset_low_q, reset_wait_q, reset_tail_q, pres_timeout_q;
  logic [7:0]  slot_low_q, slot_sample_q, slot_hold_q;

  // Input stage.
  logic       in_valid_q;
  logic [2:0] kind_q;
  logic       line_q;
  logic [7:0] data_q;

  // Sequencer state.
  owtm_pkg::phase_e phase_q, phase_d;
  logic [15:0] tick_count_q, tick_count_d;
  logic [3:0]  bit_index_q, bit_index_d;
  logic [7:0]  shift_q, shift_d;
  logic [3:0]  step_q, step_d;
  logic [7:0]  low_byte_q, low_byte_d;
  logic        presence_q, presence_d;
  logic [15:0] last_temp_q, last_temp_d;

  // Result stage.
  logic            out_valid_q;
  owtm_pkg::res_t  res_q, res_d;

  logic        advance;
  logic [15:0] tmr_dur;
  logic [15:0] tmr_inc;
  logic        tmr_hit;
  logic [3:0]  bit_inc;
  logic        op_end;
  logic        start_op;
  logic        done;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_low_q    <= 16'd100;
      reset_wait_q   <= 16'd8;
      reset_tail_q   <= 16'd100;
      slot_low_q     <= 8'd1;
      slot_sample_q  <= 8'd1;
      slot_hold_q    <= 8'd15;
      pres_timeout_q <= 16'd1000;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        owtm_pkg::CFG_RESET_LOW:    reset_low_q    <= cfg_i.data;
        owtm_pkg::CFG_RESET_WAIT:   reset_wait_q   <= cfg_i.data;
        owtm_pkg::CFG_RESET_TAIL:   reset_tail_q   <= cfg_i.data;
        owtm_pkg::CFG_SLOT_LOW:     slot_low_q     <= cfg_i.data[7:0];
        owtm_pkg::CFG_SLOT_SAMPLE:  slot_sample_q  <= cfg_i.data[7:0];
        owtm_pkg::CFG_SLOT_HOLD:    slot_hold_q    <= cfg_i.data[7:0];
        owtm_pkg::CFG_PRES_TIMEOUT: pres_timeout_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input register: one item waits here for the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      kind_q <= in_i.kind;
      line_q <= in_i.line_level;
      data_q <= in_i.data_byte;
    end
  end

  // Duration of the current phase; a zero count behaves as one tick.
  always_comb begin
    case (phase_q)
      owtm_pkg::PH_R_LOW:  tmr_dur = reset_low_q;
      owtm_pkg::PH_R_WAIT: tmr_dur = reset_wait_q;
      owtm_pkg::PH_R_PRES: tmr_dur = pres_timeout_q;
      owtm_pkg::PH_R_TAIL: tmr_dur = reset_tail_q;
      owtm_pkg::PH_W_LOW, owtm_pkg::PH_W_REC, owtm_pkg::PH_D_LOW:
        tmr_dur = {8'd0, slot_low_q};
      owtm_pkg::PH_W_HOLD, owtm_pkg::PH_D_HOLD:
        tmr_dur = {8'd0, slot_hold_q};
      owtm_pkg::PH_D_WAIT: tmr_dur = {8'd0, slot_sample_q};
      default:             tmr_dur = 16'hFFFF;
    endcase
  end

  assign tmr_inc = tick_count_q + 16'd1;
  assign tmr_hit = (tmr_inc >= tmr_dur);
  assign bit_inc = bit_index_q + 4'd1;

  // Sequencer: one tick or command per pass.
  always_comb begin
    phase_d      = phase_q;
    tick_count_d = tick_count_q;
    bit_index_d  = bit_index_q;
    shift_d      = shift_q;
    step_d       = step_q;
    low_byte_d   = low_byte_q;
    presence_d   = presence_q;
    last_temp_d  = last_temp_q;
    op_end       = 1'b0;
    start_op     = 1'b0;
    done         = 1'b0;
    res_d        = '0;

    if (kind_q == owtm_pkg::KIND_TICK) begin
      res_d.drive_low = owtm_pkg::drive_of(phase_q, shift_q[0]);
      if (phase_q != owtm_pkg::PH_IDLE) begin
        tick_count_d = tmr_hit ? 16'd0 : tmr_inc;
        case (phase_q)
          owtm_pkg::PH_R_LOW: begin
            if (tmr_hit) phase_d = owtm_pkg::PH_R_WAIT;
          end
          owtm_pkg::PH_R_WAIT: begin
            if (tmr_hit) phase_d = owtm_pkg::PH_R_PRES;
          end
          owtm_pkg::PH_R_PRES: begin
            // A low line wins over a timeout on the same tick.
            if (!line_q) begin
              presence_d   = 1'b1;
              tick_count_d = 16'd0;
              phase_d      = owtm_pkg::PH_R_TAIL;
            end else if (tmr_hit) begin
              presence_d = 1'b0;
              phase_d    = owtm_pkg::PH_IDLE;
              done       = 1'b1;
            end
          end
          owtm_pkg::PH_R_TAIL: begin
            if (tmr_hit) op_end = 1'b1;
          end
          owtm_pkg::PH_W_LOW: begin
            if (tmr_hit) phase_d = owtm_pkg::PH_W_HOLD;
          end
          owtm_pkg::PH_W_HOLD: begin
            if (tmr_hit) phase_d = owtm_pkg::PH_W_REC;
          end
          owtm_pkg::PH_W_REC: begin
            if (tmr_hit) begin
              shift_d     = {1'b0, shift_q[7:1]};
              bit_index_d = bit_inc;
              if (bit_inc[3]) op_end = 1'b1;
              else phase_d = owtm_pkg::PH_W_LOW;
            end
          end
          owtm_pkg::PH_D_LOW: begin
            if (tmr_hit) phase_d = owtm_pkg::PH_D_WAIT;
          end
          owtm_pkg::PH_D_WAIT: begin
            if (tmr_hit) begin
              shift_d = {line_q, shift_q[7:1]};
              phase_d = owtm_pkg::PH_D_HOLD;
            end
          end
          owtm_pkg::PH_D_HOLD: begin
            if (tmr_hit) begin
              bit_index_d = bit_inc;
              if (bit_inc[3]) op_end = 1'b1;
              else phase_d = owtm_pkg::PH_D_LOW;
            end
          end
          default: begin
            phase_d = owtm_pkg::PH_IDLE;
          end
        endcase
      end

      // End of one bus operation: store bytes, then next step or finish.
      if (op_end) begin
        if (step_q == owtm_pkg::STEP_LOW_BYTE) low_byte_d = shift_d;
        if (step_q == owtm_pkg::STEP_HIGH_BYTE) begin
          last_temp_d = owtm_pkg::convert_temp(low_byte_q, shift_d);
        end
        if (step_q < owtm_pkg::STEP_LAST_TEMP) begin
          step_d   = step_q + 4'd1;
          start_op = 1'b1;
        end else begin
          phase_d      = owtm_pkg::PH_IDLE;
          tick_count_d = 16'd0;
          done         = 1'b1;
        end
      end
    end else if (phase_q == owtm_pkg::PH_IDLE && kind_q <= owtm_pkg::KIND_TEMP) begin
      start_op = 1'b1;
      case (kind_q)
        owtm_pkg::KIND_RESET: step_d = owtm_pkg::STEP_RESET;
        owtm_pkg::KIND_WRITE: begin
          step_d  = owtm_pkg::STEP_WRITE;
          shift_d = data_q;
        end
        owtm_pkg::KIND_READ:  step_d = owtm_pkg::STEP_READ;
        default:              step_d = owtm_pkg::STEP_FIRST;
      endcase
    end

    // Launch the bus operation of the current step.
    if (start_op) begin
      tick_count_d = 16'd0;
      bit_index_d  = 4'd0;
      if (step_d == owtm_pkg::STEP_FIRST || step_d == owtm_pkg::STEP_RESET_END ||
          step_d == owtm_pkg::STEP_RESET_CONV || step_d == owtm_pkg::STEP_RESET) begin
        phase_d = owtm_pkg::PH_R_LOW;
      end else if (step_d == owtm_pkg::STEP_LOW_BYTE ||
                   step_d == owtm_pkg::STEP_HIGH_BYTE ||
                   step_d == owtm_pkg::STEP_READ) begin
        shift_d = 8'd0;
        phase_d = owtm_pkg::PH_D_LOW;
      end else begin
        if (step_d <= owtm_pkg::STEP_LAST_TEMP) shift_d = owtm_pkg::step_code(step_d);
        phase_d = owtm_pkg::PH_W_LOW;
      end
    end

    // Result fields.
    if (kind_q != owtm_pkg::KIND_TICK) begin
      res_d.drive_low = owtm_pkg::drive_of(phase_d, shift_d[0]);
    end
    res_d.busy_res    = (phase_d != owtm_pkg::PH_IDLE);
    res_d.cmd_done    = done;
    res_d.read_value  = (done && step_d == owtm_pkg::STEP_READ) ? shift_d : 8'd0;
    res_d.temperature = last_temp_d;
    res_d.presence    = presence_d;
  end

  // Sequencer state registers, updated once per processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= owtm_pkg::PH_IDLE;
      tick_count_q <= 16'd0;
      bit_index_q  <= 4'd0;
      shift_q      <= 8'd0;
      step_q       <= 4'd0;
      low_byte_q   <= 8'd0;
      presence_q   <= 1'b0;
      last_temp_q  <= 16'd0;
    end else if (advance) begin
      phase_q      <= phase_d;
      tick_count_q <= tick_count_d;
      bit_index_q  <= bit_index_d;
      shift_q      <= shift_d;
      step_q       <= step_d;
      low_byte_q   <= low_byte_d;
      presence_q   <= presence_d;
      last_temp_q  <= last_temp_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.drive_low   = res_q.drive_low;
  assign out_o.busy_res    = res_q.busy_res;
  assign out_o.cmd_done    = res_q.cmd_done;
  assign out_o.read_value  = res_q.read_value;
  assign out_o.temperature = res_q.temperature;
  assign out_o.presence    = res_q.presence;

  // Checks on the sequencer and the pipeline.
  `OWTM_ASSERT_IMP(a_ready_when_empty, !in_valid_q, in_i.ready, "input stage empty but not ready")
  `OWTM_ASSERT_IMP(a_idle_count_zero, phase_q == owtm_pkg::PH_IDLE, tick_count_q == 16'd0, "tick count not cleared in idle")
  `OWTM_ASSERT(a_bit_index_range, bit_index_q <= 4'd8, "bit index beyond one byte")
  `OWTM_ASSERT_IMP(a_done_not_busy, out_valid_q && res_q.cmd_done, !res_q.busy_res, "done result still busy")
  `OWTM_ASSERT_IMP(a_read_value_done, out_valid_q && !res_q.cmd_done, res_q.read_value == 8'd0, "read value without done")

endmodule
